// ===== hw/rtl/skf_pkg.sv =====
package skf_pkg;

    // Default parameter values.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Gain format: unsigned Q0.16 plus the integer bit that represents exactly one.
    localparam int GAIN_BITS  = 16;
    localparam int QUOT_BITS  = GAIN_BITS + 1;
    localparam int STEP_W     = $clog2(QUOT_BITS + 1);

    // Reset values in whole units; shifted by FRAC_BITS at the top level.
    localparam int RESET_MEAS_VAR_UNITS = 3;
    localparam int RESET_VARIANCE_UNITS = 5;
    localparam int RESET_ESTIMATE_UNITS = 40;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MEAS_VAR = 2'd0,
        REG_INIT_VAR = 2'd1,
        REG_INIT_EST = 2'd2
    } skf_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } skf_state_t;

    // Control handed to the serial units.
    typedef struct packed {
        logic start;
        logic step;
    } skf_ctl_t;

endpackage

// ===== hw/rtl/skf_div.sv =====
// Bit-serial restoring divider: one gain bit per step, most significant first.
module skf_div #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  skf_pkg::skf_ctl_t                ctl,
    input  logic [DATA_WIDTH-1:0]            dividend,
    input  logic [DATA_WIDTH:0]              divisor,
    output logic                             q_bit,
    output logic [skf_pkg::QUOT_BITS-1:0]    quotient
);

    logic [DATA_WIDTH:0]            rem_reg;
    logic [DATA_WIDTH:0]            rem_next;
    logic [DATA_WIDTH:0]            div_reg;
    logic                           first_reg;
    logic                           first_next;
    logic                           qbit_reg;
    logic                           qbit_next;
    logic [skf_pkg::QUOT_BITS-1:0]  quot_reg;
    logic [skf_pkg::QUOT_BITS-1:0]  quot_next;
    logic [DATA_WIDTH+1:0]          trial;
    logic [DATA_WIDTH+1:0]          rem_after;
    logic                           take;

    // The first step compares the dividend itself; later steps shift first.
    // A zero divisor yields a zero gain.
    always_comb
    begin
        trial     = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        take      = (div_reg != '0) && (trial >= {1'b0, div_reg});
        rem_after = take ? (trial - {1'b0, div_reg}) : trial;
    end

    // Next values of the iteration registers.
    always_comb
    begin
        rem_next   = rem_reg;
        first_next = first_reg;
        qbit_next  = qbit_reg;
        quot_next  = quot_reg;
        if (ctl.start)
        begin
            rem_next   = {1'b0, dividend};
            first_next = 1'b1;
            qbit_next  = 1'b0;
            quot_next  = '0;
        end
        else if (ctl.step)
        begin
            rem_next   = rem_after[DATA_WIDTH:0];
            first_next = 1'b0;
            qbit_next  = take;
            quot_next  = {quot_reg[skf_pkg::QUOT_BITS-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            qbit_reg  <= 1'b0;
            quot_reg  <= '0;
        end
        else
        begin
            first_reg <= first_next;
            qbit_reg  <= qbit_next;
            quot_reg  <= quot_next;
        end
    end

    // The divisor is held while the divider runs; the remainder changes on each step.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (ctl.start)
        begin
            div_reg <= divisor;
        end
    end

    assign q_bit    = qbit_reg;
    assign quotient = quot_reg;

endmodule

// ===== hw/rtl/skf_mac.sv =====
// Bit-serial signed multiplier: takes the multiplier one bit per step,
// most significant first, and accumulates shift and add.
module skf_mac #(
    parameter int OP_W = skf_pkg::DATA_WIDTH_DEF + 1
) (
    input  logic                                   clk,
    input  skf_pkg::skf_ctl_t                      ctl,
    input  logic signed [OP_W-1:0]                 operand,
    input  logic                                   mult_bit,
    output logic signed [OP_W+skf_pkg::QUOT_BITS-1:0] product
);

    localparam int ACC_W = OP_W + skf_pkg::QUOT_BITS;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] addend;

    // Doubling the partial sum, then adding the operand when the bit is set.
    always_comb
    begin
        addend   = mult_bit ? ACC_W'(operand) : '0;
        acc_next = acc_reg;
        if (ctl.start)
        begin
            acc_next = '0;
        end
        else if (ctl.step)
        begin
            acc_next = (acc_reg <<< 1) + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

endmodule

// ===== hw/rtl/scalar_kalman_update.sv =====
// Scalar Kalman estimator of a constant value, fixed point.
// Input channel (in_valid/in_ready, measurement): one signed measurement per item.
// Output channel (out_valid/out_ready): the new estimate, the new variance and
// the gain used for that item. Every input item gives exactly one result item.
// Configuration: cfg_write with cfg_index and cfg_data writes a register:
// 0 is the measurement variance, 1 loads the estimate variance, 2 loads
// the estimate. Index 3 is ignored. Write only while no item is in flight.
// Timing: the gain comes from a bit-serial divider, 17 quotient bits at one
// bit per cycle; two bit-serial multipliers take each gain bit in the cycle
// after the divider makes it. The block takes no new item while one is in
// flight: in_ready is high only while the block is idle.
// The result sits in an output register, so the block takes the next item
// while an earlier result waits; if that result is still not taken when the
// next one is done, the block holds the new result until out_ready is seen.
// Reset restores the measurement variance to 3.0, the estimate variance to 5.0
// and the estimate to 40.0, and empties the output register.
module scalar_kalman_update #(
    parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [DATA_WIDTH-1:0]        measurement,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [DATA_WIDTH-1:0]        new_estimate,
    output logic [DATA_WIDTH-1:0]               new_variance,
    output logic [skf_pkg::QUOT_BITS-1:0]       kalman_gain
);

    localparam int OP_W  = DATA_WIDTH + 1;
    localparam int ACC_W = OP_W + skf_pkg::QUOT_BITS;
    localparam int SUM_W = DATA_WIDTH + 2;

    localparam logic [DATA_WIDTH-1:0] MEAS_VAR_RESET =
        DATA_WIDTH'(skf_pkg::RESET_MEAS_VAR_UNITS) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] VARIANCE_RESET =
        DATA_WIDTH'(skf_pkg::RESET_VARIANCE_UNITS) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] ESTIMATE_RESET =
        DATA_WIDTH'(skf_pkg::RESET_ESTIMATE_UNITS) << FRAC_BITS;
    localparam logic [skf_pkg::STEP_W-1:0] LAST_STEP =
        skf_pkg::STEP_W'(skf_pkg::QUOT_BITS);

    skf_pkg::skf_state_t state_reg;
    skf_pkg::skf_state_t state_next;

    logic [skf_pkg::STEP_W-1:0]     cnt_reg;
    logic [skf_pkg::STEP_W-1:0]     cnt_next;
    logic [DATA_WIDTH-1:0]          meas_var_reg;
    logic signed [DATA_WIDTH-1:0]   estimate_reg;
    logic [DATA_WIDTH-1:0]          variance_reg;
    logic signed [OP_W-1:0]         diff_reg;
    logic [DATA_WIDTH-1:0]          p_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [DATA_WIDTH-1:0]   out_est_reg;
    logic [DATA_WIDTH-1:0]          out_var_reg;
    logic [skf_pkg::QUOT_BITS-1:0]  out_gain_reg;

    logic                           accept;
    logic                           finish;
    skf_pkg::skf_ctl_t              div_ctl;
    skf_pkg::skf_ctl_t              mac_ctl;
    logic [DATA_WIDTH:0]            sum_pr;
    logic                           q_bit;
    logic [skf_pkg::QUOT_BITS-1:0]  quotient;
    logic signed [ACC_W-1:0]        prod_x;
    logic signed [ACC_W-1:0]        prod_p;
    logic signed [SUM_W-1:0]        delta;
    logic signed [SUM_W-1:0]        est_sum;
    logic signed [DATA_WIDTH-1:0]   est_sat;
    logic [ACC_W-1:0]               var_full;
    logic [DATA_WIDTH-1:0]          var_new;

    // Serial units.
    skf_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (variance_reg),
        .divisor  (sum_pr),
        .q_bit    (q_bit),
        .quotient (quotient)
    );

    skf_mac #(
        .OP_W (OP_W)
    ) u_mac_est (
        .clk      (clk),
        .ctl      (mac_ctl),
        .operand  (diff_reg),
        .mult_bit (q_bit),
        .product  (prod_x)
    );

    skf_mac #(
        .OP_W (OP_W)
    ) u_mac_var (
        .clk      (clk),
        .ctl      (mac_ctl),
        .operand  ($signed({1'b0, p_reg})),
        .mult_bit (q_bit),
        .product  (prod_p)
    );

    // Sum of the variances, the divisor of the gain.
    assign sum_pr = {1'b0, variance_reg} + {1'b0, meas_var_reg};

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = skf_pkg::ST_RUN;
                end
            end
            skf_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = skf_pkg::ST_DONE;
                end
            end
            skf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = skf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. Multipliers trail the divider by one step.
    always_comb
    begin
        in_ready     = 1'b0;
        finish       = 1'b0;
        div_ctl      = '0;
        mac_ctl      = '0;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                div_ctl.start = in_valid;
                mac_ctl.start = in_valid;
            end
            skf_pkg::ST_RUN:
            begin
                div_ctl.step = (cnt_reg < LAST_STEP);
                mac_ctl.step = (cnt_reg != '0);
            end
            skf_pkg::ST_DONE:
            begin
                finish = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // Estimate update: floor of diff times gain, then saturate.
    always_comb
    begin
        delta   = prod_x[ACC_W-1:skf_pkg::GAIN_BITS];
        est_sum = SUM_W'(estimate_reg) + delta;
        if (est_sum[SUM_W-1:DATA_WIDTH-1] == '0 || est_sum[SUM_W-1:DATA_WIDTH-1] == '1)
        begin
            est_sat = est_sum[DATA_WIDTH-1:0];
        end
        else if (est_sum[SUM_W-1])
        begin
            est_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            est_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    // Variance update: (one - gain) times P, as P shifted up less P times gain.
    always_comb
    begin
        var_full = (ACC_W'(p_reg) << skf_pkg::GAIN_BITS) - $unsigned(prod_p);
        var_new  = var_full[DATA_WIDTH+skf_pkg::GAIN_BITS-1:skf_pkg::GAIN_BITS];
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            meas_var_reg  <= MEAS_VAR_RESET;
            variance_reg  <= VARIANCE_RESET;
            estimate_reg  <= ESTIMATE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            priority if (finish)
            begin
                estimate_reg <= est_sat;
                variance_reg <= var_new;
            end
            else if (cfg_write)
            begin
                unique case (cfg_index)
                    skf_pkg::REG_MEAS_VAR: meas_var_reg <= cfg_data;
                    skf_pkg::REG_INIT_VAR: variance_reg <= cfg_data;
                    skf_pkg::REG_INIT_EST: estimate_reg <= cfg_data;
                    default:               meas_var_reg <= meas_var_reg;
                endcase
            end
        end
    end

    // Operands held for the serial multipliers, and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= OP_W'(measurement) - OP_W'(estimate_reg);
            p_reg    <= variance_reg;
        end
        if (finish)
        begin
            out_est_reg  <= est_sat;
            out_var_reg  <= var_new;
            out_gain_reg <= quotient;
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_estimate = out_est_reg;
    assign new_variance = out_var_reg;
    assign kalman_gain  = out_gain_reg;

endmodule

// ===== verif/tb_scalar_kalman_update.sv =====
module tb_scalar_kalman_update;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW             = skf_pkg::DATA_WIDTH_DEF;
    localparam int CLK_PERIOD     = 10;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int BATCH_ITEMS    = 50;
    localparam int PHASE_ITEMS    = 500;
    localparam int HOLD_CYCLES    = 400;

    // Index past the last register; the block must ignore writes to it.
    localparam logic [skf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [63:0]        GAIN_ONE = 64'd1 << skf_pkg::GAIN_BITS;
    localparam logic signed [63:0] EST_MAX  = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] EST_MIN  = -(64'sd1 <<< (DW - 1));

    localparam logic signed [DW-1:0] MEAS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MEAS_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic signed [DW-1:0]           estimate;
        logic [DW-1:0]                  variance;
        logic [skf_pkg::QUOT_BITS-1:0]  gain;
    } kalman_result_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                cfg_write    = 1'b0;
    logic [skf_pkg::CFG_INDEX_W-1:0]     cfg_index    = '0;
    logic [DW-1:0]                       cfg_data     = '0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic signed [DW-1:0]                measurement  = '0;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic signed [DW-1:0]                new_estimate;
    logic [DW-1:0]                       new_variance;
    logic [skf_pkg::QUOT_BITS-1:0]       kalman_gain;

    // Filter state and registers as the testbench expects them.
    logic [DW-1:0]               meas_var_reg;
    logic [DW-1:0]               init_var_reg;
    logic signed [DW-1:0]        init_est_reg;
    logic [DW-1:0]               variance_state;
    logic signed [DW-1:0]        estimate_state;

    kalman_result_t              pending_updates[$];
    int                          mismatch_count = 0;
    int                          send_idle_pct  = 0;
    int                          rx_stall_pct   = 0;
    int                          hold_request   = 0;

    scalar_kalman_update uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .measurement  (measurement),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_estimate (new_estimate),
        .new_variance (new_variance),
        .kalman_gain  (kalman_gain)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // One filter step: gain, estimate update with saturation, variance update.
    task automatic predict_update(input logic signed [DW-1:0] z);
        logic [63:0]                    p_wide;
        logic [63:0]                    var_sum;
        logic [63:0]                    quotient;
        logic [63:0]                    var_prod;
        logic [skf_pkg::QUOT_BITS-1:0]  gain;
        logic signed [63:0]             z_wide;
        logic signed [63:0]             est_wide;
        logic signed [63:0]             innovation;
        logic signed [63:0]             correction;
        logic signed [63:0]             next_est;
        kalman_result_t                 result;
        p_wide   = {{(64-DW){1'b0}}, variance_state};
        var_sum  = p_wide + {{(64-DW){1'b0}}, meas_var_reg};
        gain     = '0;
        if (var_sum != 64'd0)
        begin
            quotient = (p_wide << skf_pkg::GAIN_BITS) / var_sum;
            gain     = quotient[skf_pkg::QUOT_BITS-1:0];
        end
        z_wide     = z;
        est_wide   = estimate_state;
        innovation = z_wide - est_wide;
        // Arithmetic shift rounds the correction toward minus infinity.
        correction = (innovation * $signed({{(64-skf_pkg::QUOT_BITS){1'b0}}, gain}))
                     >>> skf_pkg::GAIN_BITS;
        next_est   = est_wide + correction;
        if (next_est > EST_MAX)
        begin
            next_est = EST_MAX;
        end
        if (next_est < EST_MIN)
        begin
            next_est = EST_MIN;
        end
        var_prod = (p_wide * (GAIN_ONE - {{(64-skf_pkg::QUOT_BITS){1'b0}}, gain}))
                   >> skf_pkg::GAIN_BITS;
        estimate_state  = next_est[DW-1:0];
        variance_state  = var_prod[DW-1:0];
        result.estimate = estimate_state;
        result.variance = variance_state;
        result.gain     = gain;
        pending_updates.push_back(result);
    endtask

    // Offer one measurement item, with an optional idle gap first.
    task automatic send_measurement(input logic signed [DW-1:0] z);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        measurement <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_update(z);
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write; the variance and estimate registers also load the state.
    task automatic write_reg(input logic [skf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [DW-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            skf_pkg::REG_MEAS_VAR:
            begin
                meas_var_reg = value;
            end
            skf_pkg::REG_INIT_VAR:
            begin
                init_var_reg   = value;
                variance_state = value;
            end
            skf_pkg::REG_INIT_EST:
            begin
                init_est_reg   = value;
                estimate_state = value;
            end
            default:
            begin
            end
        endcase
    endtask

    // Variances: mostly moderate, sometimes zero, all ones or any pattern.
    function automatic logic [DW-1:0] random_variance();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom;
            default: return $urandom_range(32'h0040_0000);
        endcase
    endfunction

    function automatic logic signed [DW-1:0] random_start_estimate();
        if ($urandom_range(1) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(32'h0100_0000) - 32'h0080_0000;
    endfunction

    // Measurements: mostly near the current estimate, some anywhere, some at the rails.
    function automatic logic signed [DW-1:0] random_measurement();
        logic signed [DW-1:0] noise;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return MEAS_MAX;
                    1:       return MEAS_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2:
            begin
                return $urandom;
            end
            default:
            begin
                noise = $urandom_range(32'h0008_0000);
                return estimate_state + noise - 32'sh0004_0000;
            end
        endcase
    endfunction

    // Each register is rewritten with some chance, so state often carries over.
    task automatic load_random_setting();
        wait_drained();
        if ($urandom_range(2) != 0)
        begin
            write_reg(skf_pkg::REG_MEAS_VAR, random_variance());
        end
        if ($urandom_range(2) != 0)
        begin
            write_reg(skf_pkg::REG_INIT_VAR, random_variance());
        end
        if ($urandom_range(2) != 0)
        begin
            write_reg(skf_pkg::REG_INIT_EST, random_start_estimate());
        end
        if ($urandom_range(15) == 0)
        begin
            write_reg(REG_UNUSED, $urandom);
        end
    endtask

    task automatic test_reset_state();
        send_measurement(32'sd42 <<< skf_pkg::FRAC_BITS_DEF);
        send_measurement(32'sd38 <<< skf_pkg::FRAC_BITS_DEF);
        send_measurement(32'sd40 <<< skf_pkg::FRAC_BITS_DEF);
    endtask

    task automatic test_measurement_extremes();
        send_measurement(MEAS_MAX);
        send_measurement(MEAS_MIN);
        send_measurement('0);
        send_measurement('1);
    endtask

    // With no measurement noise the gain is exactly one; the next step has a zero sum.
    task automatic test_zero_meas_variance();
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, '0);
        write_reg(skf_pkg::REG_INIT_VAR, 32'd5 << skf_pkg::FRAC_BITS_DEF);
        send_measurement(MEAS_MAX);
        send_measurement(MEAS_MIN);
    endtask

    task automatic test_zero_sum();
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, '0);
        write_reg(skf_pkg::REG_INIT_VAR, '0);
        write_reg(skf_pkg::REG_INIT_EST, 32'sh0001_8000);
        send_measurement(32'sh7654_3210);
    endtask

    task automatic test_register_extremes();
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, '1);
        write_reg(skf_pkg::REG_INIT_VAR, '1);
        write_reg(skf_pkg::REG_INIT_EST, MEAS_MIN);
        send_measurement(MEAS_MAX);
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, '0);
        write_reg(skf_pkg::REG_INIT_VAR, '1);
        write_reg(skf_pkg::REG_INIT_EST, MEAS_MAX);
        send_measurement(MEAS_MIN);
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, '1);
        write_reg(skf_pkg::REG_INIT_VAR, '0);
        send_measurement(MEAS_MAX);
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, 32'd1);
        write_reg(skf_pkg::REG_INIT_VAR, 32'd1);
        send_measurement(MEAS_MIN);
    endtask

    task automatic test_unused_index();
        wait_drained();
        write_reg(skf_pkg::REG_MEAS_VAR, 32'd3 << skf_pkg::FRAC_BITS_DEF);
        write_reg(skf_pkg::REG_INIT_VAR, 32'd2 << skf_pkg::FRAC_BITS_DEF);
        write_reg(REG_UNUSED, '1);
        send_measurement(32'sh0002_0000);
    endtask

    // Random settings in batches, under one idling pattern.
    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        for (int b = 0; b < PHASE_ITEMS / BATCH_ITEMS; b++)
        begin
            load_random_setting();
            for (int i = 0; i < BATCH_ITEMS; i++)
                send_measurement(random_measurement());
        end
        wait_drained();
    endtask

    // The receiver holds off long enough that the block stalls its input.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        load_random_setting();
        hold_request = HOLD_CYCLES;
        repeat (24) send_measurement(random_measurement());
        wait_drained();
    endtask

    // Receiver side: random stalls plus an occasional long hold-off.
    initial
    begin : out_ready_drive
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Compare each accepted result item with the oldest expected update.
    initial
    begin : result_check
        kalman_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_updates.size() == 0)
                begin
                    $error("result item with no measurement pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_updates.pop_front();
                    if (new_estimate !== want.estimate)
                    begin
                        $error("new_estimate: expected %0d, got %0d",
                               want.estimate, new_estimate);
                        mismatch_count++;
                    end
                    if (new_variance !== want.variance)
                    begin
                        $error("new_variance: expected %0d, got %0d",
                               want.variance, new_variance);
                        mismatch_count++;
                    end
                    if (kalman_gain !== want.gain)
                    begin
                        $error("kalman_gain: expected %0d, got %0d",
                               want.gain, kalman_gain);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("scalar_kalman_update regression: fail");
        $finish;
    end

    initial
    begin : main_sequence
        meas_var_reg   = skf_pkg::RESET_MEAS_VAR_UNITS << skf_pkg::FRAC_BITS_DEF;
        init_var_reg   = skf_pkg::RESET_VARIANCE_UNITS << skf_pkg::FRAC_BITS_DEF;
        init_est_reg   = skf_pkg::RESET_ESTIMATE_UNITS << skf_pkg::FRAC_BITS_DEF;
        variance_state = init_var_reg;
        estimate_state = init_est_reg;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_measurement_extremes();
        test_zero_meas_variance();
        test_zero_sum();
        test_register_extremes();
        test_unused_index();
        test_random_phase(0, 0);
        test_random_phase(47, 0);
        test_random_phase(0, 47);
        test_random_phase(25, 25);
        test_output_backpressure();

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("scalar_kalman_update regression: pass");
        end
        else
        begin
            $display("scalar_kalman_update regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/skf_pkg.sv
hw/rtl/skf_div.sv
hw/rtl/skf_mac.sv
hw/rtl/scalar_kalman_update.sv
verif/tb_scalar_kalman_update.sv
